[src/dfh_pkg.sv]
`timescale 1ns / 1ps
// dfh_pkg: constants, control structs and the FNV lane step for the dual FNV-1a hash.
// No dependencies; imported by dfh_core and dual_fnv_hash_128_unit.
package dfh_pkg;

	localparam logic [63:0] SEED_FWD = 64'hcbf29ce484222325;
	localparam logic [63:0] SEED_REV = 64'h9e3779b97f4a7c15;
	// FNV prime is 2^40 + 0x1b3
	localparam int unsigned PRIME_SHIFT = 40;
	localparam logic [8:0]  PRIME_LOW   = 9'h1b3;
	localparam logic [63:0] MIX_FWD = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MIX_REV = 64'hc4ceb9fe1a85ec53;

	localparam int unsigned FWD_PRE_SHIFT  = 33;
	localparam int unsigned FWD_POST_SHIFT = 33;
	localparam int unsigned REV_PRE_SHIFT  = 29;
	localparam int unsigned REV_POST_SHIFT = 32;

	typedef struct packed {
		logic start;  // last item accepted, begin a digest
		logic ovf;    // message overran the store
	} dfh_cmd_t;

	typedef struct packed {
		logic idle;   // sequencer free, can take items
		logic done;   // digest ready, held until acked
		logic ovf;    // digest belongs to an overrun message
	} dfh_rsp_t;

	// one FNV-1a byte step: xor then multiply by prime as shift plus small product
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] t;
		t = h ^ {56'd0, b};
		return (t << PRIME_SHIFT) + (t * {55'd0, PRIME_LOW});
	endfunction

endpackage

[src/dfh_ifs.sv]
`timescale 1ns / 1ps
// dfh_ifs: valid/ready channel interfaces for message bytes and digests.
// No dependencies.
interface dfh_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;

	modport source(output valid, data_byte, has_byte, last, input ready);
	modport sink(input valid, data_byte, has_byte, last, output ready);
endinterface

interface dfh_digest_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_forward;
	logic [63:0] hash_reverse;
	logic        overflowed;

	modport source(output valid, hash_forward, hash_reverse, overflowed, input ready);
	modport sink(input valid, hash_forward, hash_reverse, overflowed, output ready);
endinterface

[src/dfh_store.sv]
`timescale 1ns / 1ps
// dfh_store: message byte memory, one write port, two registered read ports.
// No package dependencies.
module dfh_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr_a,
	input  logic [AW-1:0] raddr_b,
	output logic [7:0]    rdata_a,
	output logic [7:0]    rdata_b
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

[src/dfh_mul.sv]
`timescale 1ns / 1ps
// dfh_mul: shared 32x32 multiplier with a registered 64-bit product.
// No package dependencies.
module dfh_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);

	always_ff @(posedge clk) begin
		p <= {32'd0, a} * {32'd0, b};
	end

endmodule

[src/dfh_core.sv]
`timescale 1ns / 1ps
// dfh_core: digest sequencer; walks the store for both lanes, then runs both
// avalanches through one shared multiplier. Depends on dfh_pkg, dfh_mul.
module dfh_core #(
	parameter int MAX_BYTES = 4096,
	parameter int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1,
	parameter int CW = $clog2(MAX_BYTES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  dfh_pkg::dfh_cmd_t cmd,
	input  logic [CW-1:0]     len,
	input  logic              ack,
	output dfh_pkg::dfh_rsp_t rsp,
	output logic [AW-1:0]     raddr_f,
	output logic [AW-1:0]     raddr_r,
	input  logic [7:0]        rdata_f,
	input  logic [7:0]        rdata_r,
	output logic [63:0]       lane_f,
	output logic [63:0]       lane_r
);
	import dfh_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_WALK = 2'd1;
	localparam logic [1:0] S_MIX  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	// avalanche steps: all but R_END issue a product, all but F_LL consume one
	localparam logic [2:0] MX_F_LL = 3'd0;
	localparam logic [2:0] MX_F_HL = 3'd1;
	localparam logic [2:0] MX_F_LH = 3'd2;
	localparam logic [2:0] MX_R_LL = 3'd3;
	localparam logic [2:0] MX_R_HL = 3'd4;
	localparam logic [2:0] MX_R_LH = 3'd5;
	localparam logic [2:0] MX_R_END = 3'd6;

	logic [1:0]    state_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] walk_q;
	logic          rd_vld_q;
	logic [2:0]    step_q;
	logic [63:0]   acc_q;
	logic [63:0]   lf_q;
	logic [63:0]   lr_q;
	logic          ovf_q;
	logic [CW-1:0] back;
	logic          walk_end;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [63:0]   mul_p;
	logic [63:0]   prod;

	dfh_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	assign back     = len_q - walk_q - CW'(1);
	assign raddr_f  = walk_q[AW-1:0];
	assign raddr_r  = back[AW-1:0];
	assign walk_end = (walk_q == len_q);
	// low 64 bits of x*C: lo*lo plus the two cross terms shifted up
	assign prod     = acc_q + {mul_p[31:0], 32'd0};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (step_q)
			MX_F_LL: begin mul_a = lf_q[31:0];  mul_b = MIX_FWD[31:0];  end
			MX_F_HL: begin mul_a = lf_q[63:32]; mul_b = MIX_FWD[31:0];  end
			MX_F_LH: begin mul_a = lf_q[31:0];  mul_b = MIX_FWD[63:32]; end
			MX_R_LL: begin mul_a = lr_q[31:0];  mul_b = MIX_REV[31:0];  end
			MX_R_HL: begin mul_a = lr_q[63:32]; mul_b = MIX_REV[31:0];  end
			MX_R_LH: begin mul_a = lr_q[31:0];  mul_b = MIX_REV[63:32]; end
			default: begin mul_a = '0;          mul_b = '0;             end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			walk_q   <= '0;
			rd_vld_q <= 1'b0;
			step_q   <= MX_F_LL;
			ovf_q    <= 1'b0;
			len_q    <= '0;
			lf_q     <= '0;
			lr_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.start) begin
						len_q    <= len;
						walk_q   <= '0;
						rd_vld_q <= 1'b0;
						ovf_q    <= cmd.ovf;
						if (cmd.ovf) begin
							lf_q    <= '0;
							lr_q    <= '0;
							state_q <= S_DONE;
						end else begin
							lf_q    <= SEED_FWD ^ 64'(len);
							lr_q    <= SEED_REV ^ (64'(len) << 32);
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					if (!walk_end) begin
						walk_q <= walk_q + CW'(1);
					end
					rd_vld_q <= !walk_end;
					if (rd_vld_q) begin
						lf_q <= fnv_step(lf_q, rdata_f);
						lr_q <= fnv_step(lr_q, rdata_r);
					end else if (walk_end) begin
						// first xor-shift of both avalanches
						lf_q    <= lf_q ^ (lf_q >> FWD_PRE_SHIFT);
						lr_q    <= lr_q ^ (lr_q >> REV_PRE_SHIFT);
						step_q  <= MX_F_LL;
						state_q <= S_MIX;
					end
				end
				S_MIX: begin
					step_q <= step_q + 3'd1;
					if (step_q == MX_F_LH + 3'd1) begin
						lf_q <= prod ^ (prod >> FWD_POST_SHIFT);
					end
					if (step_q == MX_R_END) begin
						lr_q    <= prod ^ (prod >> REV_POST_SHIFT);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (ack) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// partial product accumulator
	always_ff @(posedge clk) begin
		if (step_q == MX_F_HL || step_q == MX_R_HL) begin
			acc_q <= mul_p;
		end else if (step_q == MX_F_LH || step_q == MX_R_LH) begin
			acc_q <= prod;
		end
	end

	assign rsp.idle = (state_q == S_IDLE);
	assign rsp.done = (state_q == S_DONE);
	assign rsp.ovf  = ovf_q;
	assign lane_f   = lf_q;
	assign lane_r   = lr_q;

endmodule

[src/dual_fnv_hash_128_unit.sv]
`timescale 1ns / 1ps
// dual_fnv_hash_128_unit: top level of the 128-bit dual FNV-1a digest block.
// Depends on dfh_pkg, dfh_ifs, dfh_store, dfh_core (which holds dfh_mul).
//
//  channel  | dir | payload                                       | accepted when
//  ---------+-----+-----------------------------------------------+----------------------------
//  msg      | in  | data_byte[8], has_byte, last                  | msg.valid & msg.ready
//  digest   | out | hash_forward[64], hash_reverse[64], overflowed | digest.valid & digest.ready
//
// Byte items are taken while the sequencer is idle. An item with last starts
// the digest: the store walk reads every byte once for each lane through the
// registered ports, both together (no reads for an empty message), then the
// first xor-shift of both lanes is applied, then the shared 32x32 multiplier
// forms three partial products per lane, then the sequencer waits in done
// until the digest moves to the output register. An overrun message goes
// straight to done. msg.ready is low from a last item until the sequencer is
// idle again.
// A digest waiting in the output register stalls nothing until the next digest
// is done; that one then holds the sequencer in done and msg.ready low.
// arst_n clears count, overrun flag, sequencer and output valid; the store
// needs no clearing since only bytes of the current message are read.
module dual_fnv_hash_128_unit #(
	parameter int MAX_BYTES = 4096
) (
	input logic          clk,
	input logic          arst_n,
	dfh_byte_if.sink     msg,
	dfh_digest_if.source digest
);
	import dfh_pkg::*;

	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int CW = $clog2(MAX_BYTES + 1);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_BYTES);

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nx;
	logic          ovf_q;
	logic          ovf_nx;
	logic          take;
	logic          room;
	logic          wr_en;

	dfh_cmd_t      cmd;
	dfh_rsp_t      rsp;
	logic          ack;
	logic [AW-1:0] raddr_f;
	logic [AW-1:0] raddr_r;
	logic [7:0]    rdata_f;
	logic [7:0]    rdata_r;
	logic [63:0]   lane_f;
	logic [63:0]   lane_r;

	logic          out_vld_q;
	logic [63:0]   hf_q;
	logic [63:0]   hr_q;
	logic          oflow_q;

	// --- message loading ---
	assign msg.ready = rsp.idle;
	assign take      = msg.valid && msg.ready;
	assign room      = (count_q < MAX_C);
	assign wr_en     = take && msg.has_byte && room;
	assign count_nx  = wr_en ? count_q + CW'(1) : count_q;
	// bytes past the store depth are dropped and flag the overrun
	assign ovf_nx    = ovf_q || (take && msg.has_byte && !room);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			if (msg.last) begin
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else begin
				count_q <= count_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

	// last item: length includes its own byte; store write lands the same edge
	assign cmd.start = take && msg.last;
	assign cmd.ovf   = ovf_nx;

	dfh_store #(
		.DEPTH (MAX_BYTES),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (count_q[AW-1:0]),
		.wdata   (msg.data_byte),
		.raddr_a (raddr_f),
		.raddr_b (raddr_r),
		.rdata_a (rdata_f),
		.rdata_b (rdata_r)
	);

	dfh_core #(
		.MAX_BYTES (MAX_BYTES),
		.AW        (AW),
		.CW        (CW)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.len     (count_nx),
		.ack     (ack),
		.rsp     (rsp),
		.raddr_f (raddr_f),
		.raddr_r (raddr_r),
		.rdata_f (rdata_f),
		.rdata_r (rdata_r),
		.lane_f  (lane_f),
		.lane_r  (lane_r)
	);

	// --- output register: digest moves in when the slot is free or draining ---
	assign ack = rsp.done && (!out_vld_q || digest.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ack) begin
			out_vld_q <= 1'b1;
		end else if (digest.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ack) begin
			hf_q    <= lane_f;
			hr_q    <= lane_r;
			oflow_q <= rsp.ovf;
		end
	end

	assign digest.valid        = out_vld_q;
	assign digest.hash_forward = hf_q;
	assign digest.hash_reverse = hr_q;
	assign digest.overflowed   = oflow_q;

`ifndef SYNTH
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(digest.valid && digest.overflowed) |->
		(digest.hash_forward == 64'd0 && digest.hash_reverse == 64'd0))
		else $error("overrun digest carries nonzero hash");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_C)
		else $error("byte count beyond store depth");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> !rsp.idle)
		else $error("sequencer did not take a digest start");

	a_ack_done: assert property (@(posedge clk) disable iff (!arst_n)
		ack |=> (digest.valid && !rsp.done))
		else $error("digest handoff lost");
`endif

endmodule
